>>> rtl/lkvc_pkg.sv
// Shared types and constants for the LRU key-value cache.
package lkvc_pkg;

    localparam int MAX_ENTRIES = 16;
    localparam int SLOT_W      = $clog2(MAX_ENTRIES);
    localparam int RANK_W      = SLOT_W;
    localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
    localparam int CAP_W       = 5;
    localparam int KEY_W       = 32;
    localparam int VAL_W       = 32;
    localparam int CMP_W       = (CNT_W > CAP_W) ? CNT_W : CAP_W;

    localparam logic CMD_GET = 1'b0;
    localparam logic CMD_PUT = 1'b1;

    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

    typedef struct packed {
        logic                    cmd;
        logic [KEY_W-1:0]        lookup_key;
        logic signed [VAL_W-1:0] write_value;
    } in_t;

    typedef struct packed {
        logic                    hit;
        logic signed [VAL_W-1:0] read_value;
    } out_t;

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_SCAN   = 3'b010,
        ST_UPDATE = 3'b100
    } state_t;

endpackage

>>> rtl/lkvc_ram.sv
// Generic single-write, single-read RAM with registered read data.
module lkvc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> rtl/lru_key_value_cache.sv
// Fully associative key-value cache with least-recently-used replacement.
// Each request runs a sequential slot scan: one key/value RAM read per slot, one compare a cycle,
// then a commit in ST_UPDATE that waits while a held result is stalled by out_stall.
// A new request is taken only in ST_IDLE (in_stall high otherwise), so requests do not overlap.
// Reset (rst_n low, asynchronous): all entries invalid, count zero, capacity 16, no result held.
// Key and value RAM contents are not cleared; no clearing pass is needed.
module lru_key_value_cache
    import lkvc_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  in_t              in_data,
    output logic             out_valid,
    input  logic             out_stall,
    output out_t             out_data,
    input  logic             cfg_we,
    input  logic [CAP_W-1:0] cfg_data
);

    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(MAX_ENTRIES - 1);
    localparam logic [RANK_W:0]   THR_ALL   = (RANK_W + 1)'(MAX_ENTRIES);
    localparam logic [CMP_W-1:0]  CAP_MAX   = CMP_W'(MAX_ENTRIES);
    localparam logic [CMP_W-1:0]  CAP_MIN   = CMP_W'(1);

    state_t state_reg, state_next;

    logic [CAP_W-1:0]  cap_reg, cap_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [MAX_ENTRIES-1:0] valid_reg, valid_next;
    logic [RANK_W-1:0] rank_reg [MAX_ENTRIES];
    logic [RANK_W-1:0] rank_next [MAX_ENTRIES];

    logic [SLOT_W-1:0] idx_reg, idx_next;
    logic              issue_done_reg, issue_done_next;
    logic              cmp_valid_reg, cmp_valid_next;
    logic [SLOT_W-1:0] cmp_idx_reg, cmp_idx_next;

    in_t               req_reg, req_next;
    logic              found_reg, found_next;
    logic [SLOT_W-1:0] found_slot_reg, found_slot_next;
    logic [VAL_W-1:0]  rdval_reg, rdval_next;
    logic              free_found_reg, free_found_next;
    logic [SLOT_W-1:0] free_slot_reg, free_slot_next;
    logic              lru_any_reg, lru_any_next;
    logic [SLOT_W-1:0] lru_slot_reg, lru_slot_next;
    logic [RANK_W-1:0] lru_rank_reg, lru_rank_next;

    logic              out_valid_reg, out_valid_next;
    out_t              out_data_reg, out_data_next;

    logic [KEY_W-1:0]  key_rdata;
    logic [VAL_W-1:0]  val_rdata;
    logic              ram_we;
    logic [SLOT_W-1:0] ram_waddr;

    logic [CMP_W-1:0]  cap_eff;
    logic [CMP_W-1:0]  count_ext;
    logic              in_xfer;
    logic              commit;
    logic              do_promote;
    logic              do_insert;
    logic [SLOT_W-1:0] tgt_slot;
    logic [RANK_W:0]   thr;
    logic              match;

    lkvc_ram #(.WIDTH(KEY_W), .DEPTH(MAX_ENTRIES)) u_key_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (req_reg.lookup_key),
        .raddr (idx_reg),
        .rdata (key_rdata)
    );

    lkvc_ram #(.WIDTH(VAL_W), .DEPTH(MAX_ENTRIES)) u_val_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (req_reg.write_value),
        .raddr (idx_reg),
        .rdata (val_rdata)
    );

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign in_xfer   = in_valid && !in_stall;

    always_comb
    begin
        cap_eff = CMP_W'(cap_reg);
        if (cap_eff == '0)
        begin
            cap_eff = CAP_MIN;
        end
        else if (cap_eff > CAP_MAX)
        begin
            cap_eff = CAP_MAX;
        end
        count_ext = CMP_W'(count_reg);
    end

    assign match = cmp_valid_reg && valid_reg[cmp_idx_reg] && (key_rdata == req_reg.lookup_key);

    always_comb
    begin
        state_next      = state_reg;
        cap_next        = cfg_we ? cfg_data : cap_reg;
        count_next      = count_reg;
        valid_next      = valid_reg;
        rank_next       = rank_reg;
        idx_next        = idx_reg;
        issue_done_next = issue_done_reg;
        cmp_valid_next  = 1'b0;
        cmp_idx_next    = cmp_idx_reg;
        req_next        = req_reg;
        found_next      = found_reg;
        found_slot_next = found_slot_reg;
        rdval_next      = rdval_reg;
        free_found_next = free_found_reg;
        free_slot_next  = free_slot_reg;
        lru_any_next    = lru_any_reg;
        lru_slot_next   = lru_slot_reg;
        lru_rank_next   = lru_rank_reg;
        out_valid_next  = out_valid_reg && out_stall;
        out_data_next   = out_data_reg;
        commit          = 1'b0;
        do_promote      = 1'b0;
        do_insert       = 1'b0;
        tgt_slot        = found_slot_reg;
        thr             = {1'b0, rank_reg[found_slot_reg]};
        ram_we          = 1'b0;
        ram_waddr       = found_slot_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    req_next        = in_data;
                    idx_next        = '0;
                    issue_done_next = 1'b0;
                    found_next      = 1'b0;
                    free_found_next = 1'b0;
                    lru_any_next    = 1'b0;
                    state_next      = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (!issue_done_reg)
                begin
                    cmp_valid_next = 1'b1;
                    cmp_idx_next   = idx_reg;
                    idx_next       = idx_reg + 1'b1;
                    if (idx_reg == LAST_SLOT)
                    begin
                        issue_done_next = 1'b1;
                    end
                end
                if (cmp_valid_reg)
                begin
                    if (match && !found_reg)
                    begin
                        found_next      = 1'b1;
                        found_slot_next = cmp_idx_reg;
                        rdval_next      = val_rdata;
                    end
                    if (!valid_reg[cmp_idx_reg] && !free_found_reg)
                    begin
                        free_found_next = 1'b1;
                        free_slot_next  = cmp_idx_reg;
                    end
                    if (valid_reg[cmp_idx_reg]
                        && (!lru_any_reg || rank_reg[cmp_idx_reg] > lru_rank_reg))
                    begin
                        lru_any_next  = 1'b1;
                        lru_slot_next = cmp_idx_reg;
                        lru_rank_next = rank_reg[cmp_idx_reg];
                    end
                    if (cmp_idx_reg == LAST_SLOT)
                    begin
                        state_next = ST_UPDATE;
                    end
                end
            end
            ST_UPDATE:
            begin
                if (!(out_valid_reg && out_stall))
                begin
                    commit     = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (commit)
        begin
            out_valid_next          = 1'b1;
            out_data_next.hit       = found_reg;
            out_data_next.read_value = (req_reg.cmd == CMD_GET && found_reg) ? rdval_reg : '0;
            if (found_reg)
            begin
                do_promote = 1'b1;
                ram_we     = (req_reg.cmd == CMD_PUT);
            end
            else if (req_reg.cmd == CMD_PUT)
            begin
                do_promote = 1'b1;
                ram_we     = 1'b1;
                if (count_ext < cap_eff)
                begin
                    do_insert = 1'b1;
                    tgt_slot  = free_slot_reg;
                    thr       = THR_ALL;
                end
                else
                begin
                    tgt_slot = lru_slot_reg;
                    thr      = {1'b0, lru_rank_reg};
                end
            end
            ram_waddr = tgt_slot;
        end

        if (do_promote)
        begin
            for (int i = 0; i < MAX_ENTRIES; i++)
            begin
                if (SLOT_W'(i) != tgt_slot && valid_reg[i] && ({1'b0, rank_reg[i]} < thr))
                begin
                    rank_next[i] = rank_reg[i] + 1'b1;
                end
            end
            rank_next[tgt_slot] = '0;
        end

        if (do_insert)
        begin
            valid_next[tgt_slot] = 1'b1;
            count_next           = count_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            cap_reg        <= CAP_RESET;
            count_reg      <= '0;
            valid_reg      <= '0;
            issue_done_reg <= 1'b0;
            cmp_valid_reg  <= 1'b0;
            out_valid_reg  <= 1'b0;
            for (int i = 0; i < MAX_ENTRIES; i++)
            begin
                rank_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg      <= state_next;
            cap_reg        <= cap_next;
            count_reg      <= count_next;
            valid_reg      <= valid_next;
            issue_done_reg <= issue_done_next;
            cmp_valid_reg  <= cmp_valid_next;
            out_valid_reg  <= out_valid_next;
            rank_reg       <= rank_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg        <= idx_next;
        cmp_idx_reg    <= cmp_idx_next;
        req_reg        <= req_next;
        found_reg      <= found_next;
        found_slot_reg <= found_slot_next;
        rdval_reg      <= rdval_next;
        free_found_reg <= free_found_next;
        free_slot_reg  <= free_slot_next;
        lru_any_reg    <= lru_any_next;
        lru_slot_reg   <= lru_slot_next;
        lru_rank_reg   <= lru_rank_next;
        out_data_reg   <= out_data_next;
    end

`ifndef ASSERT_OFF
    a_count_matches_valid: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(valid_reg) == int'(count_reg))
        else $error("entry count disagrees with valid bits");

    a_result_from_commit: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_UPDATE))
        else $error("result raised outside commit");

    a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        int'(count_reg) <= MAX_ENTRIES)
        else $error("entry count beyond slot total");

    a_scan_ends_in_update: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN && cmp_valid_reg && cmp_idx_reg == LAST_SLOT)
        |=> (state_reg == ST_UPDATE))
        else $error("scan did not hand over to commit");
`endif

endmodule

>>> tb/lru_key_value_cache_tb.sv
// Self-checking testbench for the LRU key-value cache: mirrored cache state and result checks.
module lru_key_value_cache_tb
    import lkvc_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    class cache_mirror;
        logic [KEY_W-1:0]        keys [MAX_ENTRIES];
        logic signed [VAL_W-1:0] vals [MAX_ENTRIES];
        bit                      used [MAX_ENTRIES];
        int unsigned             rank [MAX_ENTRIES];
        int unsigned             count;
        logic [CAP_W-1:0]        capacity;
        out_t                    pending_replies[$];
        int                      errors;

        function new();
            for (int i = 0; i < MAX_ENTRIES; i++)
            begin
                keys[i] = '0;
                vals[i] = '0;
                used[i] = 1'b0;
                rank[i] = 0;
            end
            count    = 0;
            capacity = CAP_RESET;
            errors   = 0;
        endfunction

        function void set_capacity(logic [CAP_W-1:0] cap);
            capacity = cap;
        endfunction

        function void promote(int slot, int unsigned old_rank);
            for (int i = 0; i < MAX_ENTRIES; i++)
            begin
                if (i != slot && used[i] && rank[i] < old_rank)
                    rank[i]++;
            end
            rank[slot] = 0;
        endfunction

        function void note_request(in_t req);
            int   slot;
            bit   found;
            int   limit;
            int   worst;
            out_t reply;
            slot  = 0;
            found = 1'b0;
            for (int i = 0; i < MAX_ENTRIES; i++)
            begin
                if (!found && used[i] && keys[i] == req.lookup_key)
                begin
                    slot  = i;
                    found = 1'b1;
                end
            end
            reply.hit        = found;
            reply.read_value = '0;
            if (req.cmd == CMD_GET)
            begin
                if (found)
                begin
                    reply.read_value = vals[slot];
                    promote(slot, rank[slot]);
                end
            end
            else if (found)
            begin
                vals[slot] = req.write_value;
                promote(slot, rank[slot]);
            end
            else
            begin
                limit = int'(capacity);
                if (limit < 1)
                    limit = 1;
                if (limit > MAX_ENTRIES)
                    limit = MAX_ENTRIES;
                if (count < limit)
                begin
                    for (int i = MAX_ENTRIES - 1; i >= 0; i--)
                    begin
                        if (!used[i])
                            slot = i;
                    end
                    used[slot] = 1'b1;
                    keys[slot] = req.lookup_key;
                    vals[slot] = req.write_value;
                    count++;
                    promote(slot, MAX_ENTRIES);
                end
                else
                begin
                    worst = -1;
                    for (int i = 0; i < MAX_ENTRIES; i++)
                    begin
                        if (used[i] && int'(rank[i]) > worst)
                        begin
                            worst = rank[i];
                            slot  = i;
                        end
                    end
                    keys[slot] = req.lookup_key;
                    vals[slot] = req.write_value;
                    promote(slot, worst);
                end
            end
            pending_replies.insert(pending_replies.size(), reply);
        endfunction

        function void check_reply(out_t got);
            out_t want;
            if (pending_replies.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, actual hit=%0b value=%0d",
                         $time, got.hit, got.read_value);
                errors++;
                return;
            end
            want = pending_replies[0];
            pending_replies.delete(0);
            if (got.hit !== want.hit)
            begin
                $display("%0t: hit mismatch, expected %0b, actual %0b",
                         $time, want.hit, got.hit);
                errors++;
            end
            if (got.read_value !== want.read_value)
            begin
                $display("%0t: read_value mismatch, expected %0d, actual %0d",
                         $time, want.read_value, got.read_value);
                errors++;
            end
        endfunction
    endclass

    logic             clk = 1'b0;
    logic             rst_n;
    logic             in_valid;
    logic             in_stall;
    in_t              in_data;
    logic             out_valid;
    logic             out_stall;
    out_t             out_data;
    logic             cfg_we;
    logic [CAP_W-1:0] cfg_data;

    cache_mirror      mirror;
    bit               steady;
    bit               hold_off_req;
    int               hold_left;
    int               stall_left;
    logic [KEY_W-1:0] key_pool[32];
    int               pool_size;

    lru_key_value_cache uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    initial
    begin
        #20ms;
        $display("Regression FAIL");
        $finish;
    end

    function automatic int pick_gap();
        int r;
        if (steady)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic send_request(input in_t req, input int gap);
        if (gap > 0)
        begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid = 1'b1;
        in_data  = req;
        do
            @(posedge clk);
        while (in_stall);
        mirror.note_request(req);
        @(negedge clk);
    endtask

    task automatic issue(input logic cmd, input logic [KEY_W-1:0] key,
                         input logic [VAL_W-1:0] value);
        in_t req;
        req.cmd         = cmd;
        req.lookup_key  = key;
        req.write_value = value;
        send_request(req, pick_gap());
    endtask

    task automatic drain();
        in_valid = 1'b0;
        while (mirror.pending_replies.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_capacity(input logic [CAP_W-1:0] cap);
        cfg_we   = 1'b1;
        cfg_data = cap;
        @(posedge clk);
        mirror.set_capacity(cap);
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    task automatic issue_random();
        logic             cmd;
        logic [KEY_W-1:0] key;
        cmd = $urandom_range(0, 1) ? CMD_PUT : CMD_GET;
        if ($urandom_range(0, 99) < 85)
            key = key_pool[$urandom_range(0, pool_size - 1)];
        else
            key = $urandom();
        issue(cmd, key, $urandom());
    endtask

    always
    begin
        @(posedge clk);
        if (rst_n && out_valid && !out_stall)
            mirror.check_reply(out_data);
        @(negedge clk);
        if (hold_off_req)
        begin
            hold_off_req = 1'b0;
            hold_left    = 400;
        end
        if (hold_left > 0)
        begin
            out_stall = 1'b1;
            hold_left--;
        end
        else if (stall_left > 0)
        begin
            out_stall = 1'b1;
            stall_left--;
        end
        else
        begin
            out_stall  = 1'b0;
            stall_left = pick_gap();
        end
    end

    initial
    begin
        int caps[10];
        int eff;
        caps = '{1, 16, 2, 0, 31, 8, 17, 5, 12, 3};
        mirror       = new();
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        in_data      = '0;
        out_stall    = 1'b0;
        cfg_we       = 1'b0;
        cfg_data     = '0;
        steady       = 1'b0;
        hold_off_req = 1'b0;
        hold_left    = 0;
        stall_left   = 0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        repeat (2) @(negedge clk);

        write_capacity(5'd3);
        issue(CMD_GET, 32'h0000_0000, 32'h1234_5678);
        issue(CMD_PUT, 32'h0000_0000, 32'h7FFF_FFFF);
        issue(CMD_PUT, 32'hFFFF_FFFF, 32'h8000_0000);
        issue(CMD_GET, 32'h0000_0000, 32'hFFFF_FFFF);
        issue(CMD_GET, 32'hFFFF_FFFF, 32'h0000_0000);
        issue(CMD_PUT, 32'h0000_0000, 32'hFFFF_FFFF);
        issue(CMD_PUT, 32'hA5A5_A5A5, 32'h0000_0001);
        issue(CMD_PUT, 32'h5A5A_5A5A, 32'h0000_0002);
        issue(CMD_GET, 32'hFFFF_FFFF, 32'h0000_0000);
        issue(CMD_GET, 32'h0000_0000, 32'h0000_0000);
        issue(CMD_GET, 32'h5A5A_5A5A, 32'h0000_0000);
        issue(CMD_GET, 32'hA5A5_A5A5, 32'h0000_0000);
        drain();

        write_capacity(5'd0);
        issue(CMD_PUT, 32'h1234_5678, 32'hDEAD_BEEF);
        issue(CMD_PUT, 32'h0000_0000, 32'h8000_0001);
        issue(CMD_GET, 32'h1234_5678, 32'h0000_0000);
        issue(CMD_GET, 32'h0000_0000, 32'h0000_0000);
        drain();

        write_capacity(5'd31);
        issue(CMD_PUT, 32'h0000_0001, 32'h0000_0010);
        issue(CMD_PUT, 32'h0000_0002, 32'h0000_0020);
        issue(CMD_PUT, 32'h8000_0000, 32'h7FFF_FFFE);
        issue(CMD_GET, 32'h0000_0001, 32'h5555_5555);
        issue(CMD_GET, 32'h8000_0000, 32'hAAAA_AAAA);
        issue(CMD_PUT, 32'h0000_0002, 32'h8000_0000);
        issue(CMD_GET, 32'h0000_0002, 32'h0000_0000);
        drain();

        for (int p = 0; p < 10; p++)
        begin
            write_capacity(caps[p][CAP_W-1:0]);
            eff = caps[p];
            if (eff < 1)
                eff = 1;
            if (eff > MAX_ENTRIES)
                eff = MAX_ENTRIES;
            pool_size = eff + $urandom_range(0, 4);
            for (int i = 0; i < pool_size; i++)
                key_pool[i] = $urandom();
            if (p % 3 == 0)
                key_pool[0] = 32'h0000_0000;
            if (p % 3 == 1)
                key_pool[0] = 32'hFFFF_FFFF;
            steady = (p == 1 || p == 6);
            for (int n = 0; n < 160; n++)
            begin
                if (p == 2 && n == 20)
                    hold_off_req = 1'b1;
                if (p == 5 && n == 80)
                    drain();
                issue_random();
            end
            steady = 1'b0;
            drain();
        end

        while (mirror.pending_replies.size() != 0)
            @(posedge clk);
        repeat (2 * (MAX_ENTRIES + 3)) @(posedge clk);
        if (mirror.errors == 0 && mirror.pending_replies.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
